// ===== hw/rtl/ffha_pkg.sv =====
// ffha_pkg: constants, item types, segment entry and sequencer states
// for the first-fit heap allocator. No dependencies.
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 32;
    localparam int BLOCK_BYTES  = 64;
    localparam int MAX_SEGMENTS = 64;

    localparam int START_W    = $clog2(HEAP_BYTES);
    localparam int SIZE_W     = START_W + 1;
    localparam int END_W      = SIZE_W + 1;
    localparam int IDX_W      = $clog2(MAX_SEGMENTS);
    localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
    localparam int REQ_W      = 17;
    localparam int ADDR_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int NEED_W     = REQ_W + 1;
    localparam int BLOCK_LOG2 = $clog2(BLOCK_BYTES);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  req_size;
        logic [ADDR_W-1:0] payload_addr;
    } ffha_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted_addr;
    } ffha_rsp_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               free;
    } ffha_seg_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_CHK,
        S_SH_RD,
        S_SH_WR,
        S_WR_LO,
        S_WR_HI,
        S_TAKE,
        S_NXT_RD,
        S_NXT_CHK,
        S_PRV,
        S_PRV_RD,
        S_PRV_CHK,
        S_RM_CHK,
        S_RM_RD,
        S_RM_WR,
        S_WR_CUR,
        S_DONE
    } ffha_state_t;

endpackage

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// first_fit_heap_allocator_unit: first-fit heap allocator with coalescing over
// an address-ordered segment table held in one single-port-write memory.
// Depends on ffha_pkg.
//
//   channel  | valid     | stall     | item
//   ---------+-----------+-----------+------------------------------------------
//   request  | req_valid | req_stall | req_item (action, req_size, payload_addr)
//   response | rsp_valid | rsp_stall | rsp_item (status, granted_addr)
//
// A sequencer walks the segment table, reading and then checking each entry.
// An allocate scans for the first free segment that fits and, on a split, moves the
// entries above it up; a free scans for the used segment at the address and moves
// entries down on each merge. A zero size or null address is answered without a scan.
// After reset the S_INIT state writes the initial segment before the first item is taken.
// A stalled response holds; the next request is taken while it waits.
module first_fit_heap_allocator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ffha_pkg::ffha_req_t req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ffha_pkg::ffha_rsp_t rsp_item
);
    import ffha_pkg::*;

    ffha_seg_t mem [MAX_SEGMENTS];

    ffha_state_t         state_reg, state_next;
    logic                op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [NEED_W:0]     need_plus_reg, need_plus_next;
    logic [SIZE_W-1:0]   rest_reg, rest_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    fidx_reg, fidx_next;
    ffha_seg_t           ent_reg, ent_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rm_prev_reg, rm_prev_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   granted_reg, granted_next;
    logic                rsp_valid_reg;
    ffha_rsp_t           rsp_reg;
    ffha_seg_t           rd_data_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    ffha_seg_t           mem_wd;
    logic [IDX_W-1:0]    mem_ra;
    logic                rsp_load;

    logic                req_zero;
    logic [NEED_W:0]     round_sum;
    logic [NEED_W-1:0]   need_new;
    logic [SIZE_W-1:0]   match_sum;
    logic                hit;
    logic                scan_last;
    logic                split;
    logic                full;
    logic                sh_more;
    logic                rm_more;
    logic [END_W-1:0]    cur_end;
    logic [END_W-1:0]    rd_end;
    logic                nxt_touch;
    logic                prv_touch;
    logic [NEED_W:0]     rest_full;
    logic [START_W-1:0]  hi_start;
    logic [SIZE_W-1:0]   grant_lo;
    logic [SIZE_W-1:0]   grant_hi;

    assign req_zero  = (req_item.action == ACT_ALLOC) ? (req_item.req_size == '0)
                                                      : (req_item.payload_addr == '0);
    assign round_sum = (NEED_W+1)'(req_item.req_size) + (NEED_W+1)'(BLOCK_BYTES - 1);
    assign need_new  = NEED_W'({round_sum[NEED_W:BLOCK_LOG2], {BLOCK_LOG2{1'b0}}});

    assign match_sum = SIZE_W'(rd_data_reg.start) + SIZE_W'(HEADER_BYTES);
    assign hit       = (op_reg == ACT_FREE)
                     ? (!rd_data_reg.free && (match_sum == SIZE_W'(addr_reg)))
                     : (rd_data_reg.free && (NEED_W'(rd_data_reg.size) >= need_reg));
    assign scan_last = (idx_reg + CNT_W'(1)) == count_reg;
    assign split     = (NEED_W+1)'(ent_reg.size) >= need_plus_reg;
    assign full      = count_reg == CNT_W'(MAX_SEGMENTS);
    assign sh_more   = (idx_reg - CNT_W'(1)) > (CNT_W'(fidx_reg) + CNT_W'(1));
    assign rm_more   = (idx_reg + CNT_W'(1)) < count_reg;

    assign cur_end   = END_W'(ent_reg.start) + END_W'(HEADER_BYTES) + END_W'(ent_reg.size);
    assign rd_end    = END_W'(rd_data_reg.start) + END_W'(HEADER_BYTES)
                     + END_W'(rd_data_reg.size);
    assign nxt_touch = rd_data_reg.free && (cur_end == END_W'(rd_data_reg.start));
    assign prv_touch = rd_data_reg.free && (rd_end == END_W'(ent_reg.start));

    assign rest_full = (NEED_W+1)'(ent_reg.size) - (NEED_W+1)'(HEADER_BYTES)
                     - (NEED_W+1)'(need_reg);
    assign hi_start  = START_W'(SIZE_W'(ent_reg.start) + SIZE_W'(HEADER_BYTES) + rest_reg);
    assign grant_lo  = SIZE_W'(ent_reg.start) + SIZE_W'(HEADER_BYTES);
    assign grant_hi  = SIZE_W'(hi_start) + SIZE_W'(HEADER_BYTES);

    assign rsp_load  = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
                state_next = S_IDLE;
            S_IDLE:
                if (req_valid)
                begin
                    state_next = req_zero ? S_DONE : S_SCAN_RD;
                end
            S_SCAN_RD:
                state_next = S_SCAN_CHK;
            S_SCAN_CHK:
                if (hit)
                begin
                    if (op_reg == ACT_FREE)
                    begin
                        state_next = scan_last ? S_PRV : S_NXT_RD;
                    end
                    else
                    begin
                        state_next = S_SPLIT_CHK;
                    end
                end
                else
                begin
                    state_next = scan_last ? S_DONE : S_SCAN_RD;
                end
            S_SPLIT_CHK:
                if (!split)
                begin
                    state_next = S_TAKE;
                end
                else if (full)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg > (CNT_W'(fidx_reg) + CNT_W'(1)))
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_WR_LO;
                end
            S_SH_RD:
                state_next = S_SH_WR;
            S_SH_WR:
                state_next = sh_more ? S_SH_RD : S_WR_LO;
            S_WR_LO:
                state_next = S_WR_HI;
            S_WR_HI:
                state_next = S_DONE;
            S_TAKE:
                state_next = S_DONE;
            S_NXT_RD:
                state_next = S_NXT_CHK;
            S_NXT_CHK:
                state_next = nxt_touch ? S_RM_CHK : S_PRV;
            S_PRV:
                state_next = (fidx_reg != '0) ? S_PRV_RD : S_WR_CUR;
            S_PRV_RD:
                state_next = S_PRV_CHK;
            S_PRV_CHK:
                state_next = prv_touch ? S_RM_CHK : S_WR_CUR;
            S_RM_CHK:
                if (rm_more)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = rm_prev_reg ? S_DONE : S_PRV;
                end
            S_RM_RD:
                state_next = S_RM_WR;
            S_RM_WR:
                state_next = S_RM_CHK;
            S_WR_CUR:
                state_next = S_DONE;
            S_DONE:
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // memory control and datapath
    always_comb
    begin
        mem_we         = 1'b0;
        mem_wa         = fidx_reg;
        mem_wd         = ent_reg;
        mem_ra         = idx_reg[IDX_W-1:0];
        op_next        = op_reg;
        addr_next      = addr_reg;
        need_next      = need_reg;
        need_plus_next = need_plus_reg;
        rest_next      = rest_reg;
        idx_next       = idx_reg;
        fidx_next      = fidx_reg;
        ent_next       = ent_reg;
        count_next     = count_reg;
        rm_prev_next   = rm_prev_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = '{start: '0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};
            end
            S_IDLE:
                if (req_valid)
                begin
                    op_next        = req_item.action;
                    addr_next      = req_item.payload_addr;
                    need_next      = need_new;
                    need_plus_next = (NEED_W+1)'(need_new)
                                   + (NEED_W+1)'(2 * HEADER_BYTES + BLOCK_BYTES);
                    idx_next       = '0;
                    status_next    = req_zero ? ST_ZERO : ST_OK;
                    granted_next   = '0;
                end
            S_SCAN_RD:
                mem_ra = idx_reg[IDX_W-1:0];
            S_SCAN_CHK:
                if (hit)
                begin
                    ent_next  = rd_data_reg;
                    fidx_next = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (scan_last)
                    begin
                        status_next = (op_reg == ACT_FREE) ? ST_NOTFOUND : ST_NOFIT;
                    end
                end
            S_SPLIT_CHK:
            begin
                rest_next = rest_full[SIZE_W-1:0];
                idx_next  = count_reg;
                if (split && full)
                begin
                    status_next = ST_FULL;
                end
            end
            S_SH_RD:
                mem_ra = IDX_W'(idx_reg - CNT_W'(1));
            S_SH_WR:
            begin
                mem_we   = 1'b1;
                mem_wa   = idx_reg[IDX_W-1:0];
                mem_wd   = rd_data_reg;
                idx_next = idx_reg - CNT_W'(1);
            end
            S_WR_LO:
            begin
                mem_we = 1'b1;
                mem_wa = fidx_reg;
                mem_wd = '{start: ent_reg.start, size: rest_reg, free: 1'b1};
            end
            S_WR_HI:
            begin
                mem_we       = 1'b1;
                mem_wa       = fidx_reg + IDX_W'(1);
                mem_wd       = '{start: hi_start, size: SIZE_W'(need_reg), free: 1'b0};
                count_next   = count_reg + CNT_W'(1);
                granted_next = grant_hi[ADDR_W-1:0];
            end
            S_TAKE:
            begin
                mem_we       = 1'b1;
                mem_wa       = fidx_reg;
                mem_wd       = '{start: ent_reg.start, size: ent_reg.size, free: 1'b0};
                granted_next = grant_lo[ADDR_W-1:0];
            end
            S_NXT_RD:
                mem_ra = fidx_reg + IDX_W'(1);
            S_NXT_CHK:
                if (nxt_touch)
                begin
                    ent_next.size = SIZE_W'(ent_reg.size + SIZE_W'(HEADER_BYTES)
                                           + rd_data_reg.size);
                    idx_next      = CNT_W'(fidx_reg) + CNT_W'(1);
                    rm_prev_next  = 1'b0;
                end
            S_PRV:
                mem_ra = fidx_reg;
            S_PRV_RD:
                mem_ra = fidx_reg - IDX_W'(1);
            S_PRV_CHK:
                if (prv_touch)
                begin
                    mem_we       = 1'b1;
                    mem_wa       = fidx_reg - IDX_W'(1);
                    mem_wd       = '{start: rd_data_reg.start,
                                     size: SIZE_W'(rd_data_reg.size + SIZE_W'(HEADER_BYTES)
                                                   + ent_reg.size),
                                     free: 1'b1};
                    idx_next     = CNT_W'(fidx_reg);
                    rm_prev_next = 1'b1;
                end
            S_RM_CHK:
                if (!rm_more)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            S_RM_RD:
                mem_ra = IDX_W'(idx_reg + CNT_W'(1));
            S_RM_WR:
            begin
                mem_we   = 1'b1;
                mem_wa   = idx_reg[IDX_W-1:0];
                mem_wd   = rd_data_reg;
                idx_next = idx_reg + CNT_W'(1);
            end
            S_WR_CUR:
            begin
                mem_we = 1'b1;
                mem_wa = fidx_reg;
                mem_wd = '{start: ent_reg.start, size: ent_reg.size, free: 1'b1};
            end
            S_DONE:
                mem_ra = fidx_reg;
            default:
                mem_ra = fidx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE && rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        need_reg      <= need_next;
        need_plus_reg <= need_plus_next;
        rest_reg      <= rest_next;
        idx_reg       <= idx_next;
        fidx_reg      <= fidx_next;
        ent_reg       <= ent_next;
        rm_prev_reg   <= rm_prev_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        if (state_reg == S_DONE && rsp_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.granted_addr <= granted_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

// ===== hw/rtl/ffha_checker.sv =====
// ffha_checker: port-level assertions for first_fit_heap_allocator_unit,
// attached by the bind below. Depends on ffha_pkg.
module ffha_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input ffha_pkg::ffha_req_t req_item,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input ffha_pkg::ffha_rsp_t rsp_item
);
    import ffha_pkg::*;

    logic req_taken;
    assign req_taken = req_valid && !req_stall && (req_item.action == ACT_ALLOC
                                                   || req_item.action == ACT_FREE);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled response changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_taken |=> req_stall)
        else $error("request taken while previous item still in work");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != ST_OK |-> rsp_item.granted_addr == '0)
        else $error("failed request carries an address");

    a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.granted_addr & ADDR_W'(HEADER_BYTES - 1)) == '0)
        else $error("granted address not header aligned");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.status <= ST_FULL)
        else $error("status code out of range");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

// ===== test/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_heap_allocator_unit: a segment-table predictor
// forecasts every response. Uses ffha_pkg and the RTL only.
module first_fit_heap_allocator_unit_tb;
    import ffha_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    ffha_req_t req_item;
    logic      rsp_valid;
    logic      rsp_stall;
    ffha_rsp_t rsp_item;

    logic [START_W-1:0] tbl_start [MAX_SEGMENTS];
    logic [SIZE_W-1:0]  tbl_size  [MAX_SEGMENTS];
    logic               tbl_free  [MAX_SEGMENTS];
    int                 tbl_count;

    ffha_rsp_t         owed_rsp [$];
    logic [ADDR_W-1:0] held_addrs [$];
    logic [ADDR_W-1:0] last_grant;
    logic [ADDR_W-1:0] last_freed;
    int                src_idle_pct;
    int                rsp_stall_pct;
    int                mismatches;

    first_fit_heap_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void heap_reset();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            tbl_start[k] = '0;
            tbl_size[k]  = '0;
            tbl_free[k]  = 1'b0;
        end
        tbl_size[0] = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
    endfunction

    function automatic void drop_entry(input int k);
        for (int j = k; j + 1 < tbl_count; j++)
        begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
            tbl_free[j]  = tbl_free[j+1];
        end
        tbl_start[tbl_count-1] = '0;
        tbl_size[tbl_count-1]  = '0;
        tbl_free[tbl_count-1]  = 1'b0;
        tbl_count--;
    endfunction

    function automatic bit adjacent(input int a, input int b);
        return int'(tbl_start[a]) + HEADER_BYTES + int'(tbl_size[a]) == int'(tbl_start[b]);
    endfunction

    function automatic ffha_rsp_t heap_alloc(input logic [REQ_W-1:0] sz);
        ffha_rsp_t r;
        int        need;
        int        rest;
        int        i;
        r = '0;
        r.status = ST_OK;
        if (sz == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        need = ((int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
        i = 0;
        while (i < tbl_count && !(tbl_free[i] && int'(tbl_size[i]) >= need))
            i++;
        if (i >= tbl_count)
        begin
            r.status = ST_NOFIT;
            return r;
        end
        rest = int'(tbl_size[i]) - HEADER_BYTES - need;
        if (rest >= HEADER_BYTES + BLOCK_BYTES)
        begin
            if (tbl_count >= MAX_SEGMENTS)
            begin
                r.status = ST_FULL;
                return r;
            end
            for (int j = tbl_count; j > i + 1; j--)
            begin
                tbl_start[j] = tbl_start[j-1];
                tbl_size[j]  = tbl_size[j-1];
                tbl_free[j]  = tbl_free[j-1];
            end
            tbl_size[i]    = SIZE_W'(rest);
            tbl_start[i+1] = START_W'(int'(tbl_start[i]) + HEADER_BYTES + rest);
            tbl_size[i+1]  = SIZE_W'(need);
            tbl_free[i+1]  = 1'b0;
            tbl_count++;
            r.granted_addr = ADDR_W'(int'(tbl_start[i+1]) + HEADER_BYTES);
        end
        else
        begin
            tbl_free[i]    = 1'b0;
            r.granted_addr = ADDR_W'(int'(tbl_start[i]) + HEADER_BYTES);
        end
        return r;
    endfunction

    function automatic ffha_rsp_t heap_free(input logic [ADDR_W-1:0] addr);
        ffha_rsp_t r;
        int        i;
        r = '0;
        r.status = ST_OK;
        if (addr == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        i = 0;
        while (i < tbl_count &&
               !(!tbl_free[i] && int'(tbl_start[i]) + HEADER_BYTES == int'(addr)))
            i++;
        if (i >= tbl_count)
        begin
            r.status = ST_NOTFOUND;
            return r;
        end
        tbl_free[i] = 1'b1;
        if (i + 1 < tbl_count && tbl_free[i+1] && adjacent(i, i + 1))
        begin
            tbl_size[i] = SIZE_W'(int'(tbl_size[i]) + HEADER_BYTES + int'(tbl_size[i+1]));
            drop_entry(i + 1);
        end
        if (i > 0 && tbl_free[i-1] && adjacent(i - 1, i))
        begin
            tbl_size[i-1] = SIZE_W'(int'(tbl_size[i-1]) + HEADER_BYTES + int'(tbl_size[i]));
            drop_entry(i);
        end
        return r;
    endfunction

    function automatic ffha_req_t alloc_item(input int sz);
        ffha_req_t it;
        it.action       = ACT_ALLOC;
        it.req_size     = REQ_W'(sz);
        it.payload_addr = ADDR_W'($urandom);
        return it;
    endfunction

    function automatic ffha_req_t free_item(input logic [ADDR_W-1:0] addr);
        ffha_req_t it;
        it.action       = ACT_FREE;
        it.req_size     = REQ_W'($urandom);
        it.payload_addr = addr;
        return it;
    endfunction

    task automatic predict(input ffha_req_t it);
        ffha_rsp_t r;
        if (it.action == ACT_ALLOC)
            r = heap_alloc(it.req_size);
        else
            r = heap_free(it.payload_addr);
        owed_rsp.push_back(r);
        last_grant = r.granted_addr;
        if (r.status == ST_OK && it.action == ACT_ALLOC)
            held_addrs.push_back(r.granted_addr);
        if (r.status == ST_OK && it.action == ACT_FREE)
        begin
            last_freed = it.payload_addr;
            for (int k = 0; k < held_addrs.size(); k++)
                if (held_addrs[k] == it.payload_addr)
                begin
                    held_addrs.delete(k);
                    break;
                end
        end
    endtask

    task automatic send_item(input ffha_req_t it);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict(it);
    endtask

    task automatic free_random_held();
        int idx;
        idx = $urandom_range(held_addrs.size() - 1);
        send_item(free_item(held_addrs[idx]));
    endtask

    task automatic test_edge_sizes();
        logic [ADDR_W-1:0] a;
        send_item(alloc_item(0));
        send_item(free_item('0));
        send_item(alloc_item(HEAP_BYTES));
        send_item(alloc_item(HEAP_BYTES - HEADER_BYTES + 1));
        send_item(alloc_item(HEAP_BYTES - HEADER_BYTES - BLOCK_BYTES));
        a = last_grant;
        send_item(alloc_item(1));
        send_item(free_item(a + ADDR_W'(1)));
        send_item(free_item(a));
        send_item(free_item(a));
        send_item(free_item('1));
    endtask

    task automatic test_merge_order();
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] mid;
        logic [ADDR_W-1:0] lo;
        send_item(alloc_item(100));
        hi = last_grant;
        send_item(alloc_item(BLOCK_BYTES));
        mid = last_grant;
        send_item(alloc_item(1));
        lo = last_grant;
        send_item(free_item(mid + ADDR_W'(BLOCK_BYTES / 2)));
        send_item(free_item(mid));
        send_item(free_item(hi));
        send_item(free_item(lo));
        send_item(free_item(lo));
    endtask

    task automatic test_table_full();
        int guard;
        guard = 0;
        while (tbl_count < MAX_SEGMENTS && guard < 2 * MAX_SEGMENTS)
        begin
            send_item(alloc_item($urandom_range(1, BLOCK_BYTES)));
            guard++;
        end
        send_item(alloc_item($urandom_range(1, 3 * BLOCK_BYTES)));
        send_item(alloc_item(1));
        while (held_addrs.size() != 0)
            free_random_held();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int roll;
        int sz;
        src_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                send_item(free_item(ADDR_W'($urandom)));
            else if (roll < 5)
                send_item(free_item('0));
            else if (roll < 8)
                send_item(free_item(last_freed));
            else if (roll < 12 && held_addrs.size() != 0)
                send_item(free_item(held_addrs[$urandom_range(held_addrs.size() - 1)]
                                    + ADDR_W'($urandom_range(1, 2 * BLOCK_BYTES))));
            else if (held_addrs.size() != 0 && (roll < 52 || held_addrs.size() > 40))
                free_random_held();
            else
            begin
                roll = $urandom_range(99);
                if (roll < 2)
                    sz = 0;
                else if (roll < 72)
                    sz = $urandom_range(1, 1024);
                else if (roll < 92)
                    sz = $urandom_range(1025, 8192);
                else
                    sz = $urandom_range(8193, HEAP_BYTES);
                send_item(alloc_item(sz));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp.size() == 0)
            begin
                $display("%0t unexpected response: expected none, got status %0d addr %0d",
                         $time, rsp_item.status, rsp_item.granted_addr);
                mismatches++;
            end
            else
            begin
                if (rsp_item.status !== owed_rsp[0].status)
                begin
                    $display("%0t status mismatch: expected %0d, got %0d",
                             $time, owed_rsp[0].status, rsp_item.status);
                    mismatches++;
                end
                if (rsp_item.granted_addr !== owed_rsp[0].granted_addr)
                begin
                    $display("%0t granted_addr mismatch: expected %0d, got %0d",
                             $time, owed_rsp[0].granted_addr, rsp_item.granted_addr);
                    mismatches++;
                end
                void'(owed_rsp.pop_front());
            end
        end
    end

    initial
    begin
        mismatches    = 0;
        src_idle_pct  = 0;
        rsp_stall_pct = 0;
        last_grant    = '0;
        last_freed    = '0;
        heap_reset();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_sizes();
        test_merge_order();
        test_table_full();
        test_random_traffic(320, 0, 0);
        test_random_traffic(320, 70, 0);
        test_random_traffic(320, 0, 70);
        test_random_traffic(320, 9, 9);

        req_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (4 * MAX_SEGMENTS + 16) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
